[hw/rtl/bez_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, payload types and lane control for the Bezier evaluator.
package bez_pkg;

	localparam int MAX_POINTS  = 8;
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int CNT_W       = 4;
	localparam int COORD_W     = 32;
	localparam int T_FRAC_BITS = 16;
	localparam int T_W         = T_FRAC_BITS + 1;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int PROD_W      = T_W + 1 + DIFF_W;
	localparam int SUM_W       = COORD_W + 4;

	localparam logic [T_W-1:0]   T_ONE       = T_W'(1) << T_FRAC_BITS;
	localparam logic [CNT_W-1:0] POINTS_MIN  = CNT_W'(2);
	localparam logic [CNT_W-1:0] POINTS_MAX  = CNT_W'(MAX_POINTS);
	localparam logic [CNT_W-1:0] POINTS_RST  = CNT_W'(4);

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	typedef struct packed {
		logic                      func;
		logic [2:0]                point_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [T_W-1:0]            t_value;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] curve_x;
		logic signed [COORD_W-1:0] curve_y;
		logic signed [COORD_W-1:0] curve_z;
	} result_t;

	typedef struct packed {
		logic             load_en;
		logic [IDX_W-1:0] load_idx;
		logic             copy;
		logic             pop;
		logic             mul_en;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [T_W-1:0]   t;
	} lane_ctl_t;

endpackage

[hw/rtl/bez_lane.sv]
`timescale 1ns / 1ps
// One coordinate lane: point store column, work queue and two-stage interpolator.
module bez_lane import bez_pkg::*; (
	input  logic                      clk,
	input  lane_ctl_t                 ctl,
	input  logic signed [COORD_W-1:0] load_coord,
	output logic signed [COORD_W-1:0] final_coord
);

	logic signed [COORD_W-1:0] store_q [MAX_POINTS];
	logic signed [COORD_W-1:0] work_q  [MAX_POINTS];
	logic signed [COORD_W-1:0] a_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PROD_W-1:0]  shifted;
	logic signed [SUM_W-1:0]   sum;
	logic signed [COORD_W-1:0] res;

	always_ff @(posedge clk) begin
		if (ctl.load_en) begin
			store_q[ctl.load_idx] <= load_coord;
		end
	end

	assign diff = $signed({work_q[1][COORD_W-1], work_q[1]})
		- $signed({work_q[0][COORD_W-1], work_q[0]});

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			a_s1    <= work_q[0];
			prod_s1 <= $signed({1'b0, ctl.t}) * diff;
		end
	end

	assign shifted = prod_s1 >>> T_FRAC_BITS;
	assign sum = $signed({{(SUM_W-COORD_W){a_s1[COORD_W-1]}}, a_s1})
		+ $signed(shifted[SUM_W-1:0]);

	always_comb begin
		if (sum[SUM_W-1:COORD_W-1] == '0 || sum[SUM_W-1:COORD_W-1] == '1) begin
			res = sum[COORD_W-1:0];
		end else if (sum[SUM_W-1]) begin
			res = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.copy) begin
			work_q <= store_q;
		end else if (ctl.pop) begin
			for (int k = 0; k < MAX_POINTS - 1; k++) begin
				work_q[k] <= work_q[k+1];
			end
		end else if (ctl.wr_en) begin
			work_q[ctl.wr_idx] <= res;
		end
	end

	assign final_coord = work_q[1];

endmodule

[hw/rtl/bez_merge.sv]
`timescale 1ns / 1ps
// Output stage: merges the three lane results into one registered result word.
module bez_merge import bez_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic signed [COORD_W-1:0] lane_x,
	input  logic signed [COORD_W-1:0] lane_y,
	input  logic signed [COORD_W-1:0] lane_z,
	output logic                      free,
	output logic                      result_valid,
	input  logic                      result_ready,
	output result_t                   result
);

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && free) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q.curve_x <= lane_x;
			data_q.curve_y <= lane_y;
			data_q.curve_z <= lane_z;
		end
	end

	assign result_valid = valid_q;
	assign result       = data_q;

endmodule

[hw/rtl/bezier_de_casteljau_eval_top.sv]
`timescale 1ns / 1ps
// Top level of the de Casteljau Bezier curve evaluator.
//
// The item channel (item_valid/item_ready/item) takes load and evaluate words.
// A load word writes one control point into the point store and
// gives no result; loads are taken back to back while the block is idle.
// An evaluate word runs de Casteljau over the first point_count points, with
// three coordinate lanes side by side. Each interpolation runs in the lane as
// a multiply, then an add and saturate; each level but the last ends with a
// drop step that discards the spent point. item_ready is low while an
// evaluate is in flight, so no new word is taken until it has finished.
// The result channel (result_valid/result_ready/result) has its own output
// register: when the receiver stalls, the word holds there and the block
// takes loads meanwhile; a later evaluate waits at its end until the
// register frees.
// cfg_wr_en/cfg_wr_data write point_count, clamped to 2..8 when used.
// Reset clears the sequencer and the output valid and sets point_count to 4;
// the point store is undefined until loaded.
module bezier_de_casteljau_eval_top import bez_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_DROP = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] point_count_q;
	logic [CNT_W-1:0] n_eff;
	logic [IDX_W-1:0] level_q;
	logic [IDX_W-1:0] step_q;
	logic [T_W-1:0]   t_q;
	logic             accept;
	logic             eval_accept;
	logic             merge_free;
	logic             merge_load;
	lane_ctl_t        ctl;
	logic signed [COORD_W-1:0] fin_x, fin_y, fin_z;

	assign item_ready  = (state_q == ST_IDLE);
	assign accept      = item_valid && item_ready;
	assign eval_accept = accept && (item.func == FUNC_EVAL);
	assign merge_load  = (state_q == ST_DONE);

	always_comb begin
		if (point_count_q < POINTS_MIN) begin
			n_eff = POINTS_MIN;
		end else if (point_count_q > POINTS_MAX) begin
			n_eff = POINTS_MAX;
		end else begin
			n_eff = point_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= POINTS_RST;
		end else if (cfg_wr_en) begin
			point_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_accept) begin
			t_q <= (item.t_value > T_ONE) ? T_ONE : item.t_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			level_q <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (eval_accept) begin
						level_q <= IDX_W'(n_eff - CNT_W'(1));
						step_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (step_q == level_q - IDX_W'(1)) begin
						state_q <= (level_q == IDX_W'(1)) ? ST_DONE : ST_DROP;
					end else begin
						step_q  <= step_q + IDX_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_DROP: begin
					level_q <= level_q - IDX_W'(1);
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_DONE: begin
					if (merge_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl.load_en  = accept && (item.func == FUNC_LOAD);
		ctl.load_idx = item.point_index;
		ctl.copy     = eval_accept;
		ctl.pop      = (state_q == ST_MUL) || (state_q == ST_DROP);
		ctl.mul_en   = (state_q == ST_MUL);
		ctl.wr_en    = (state_q == ST_ADD);
		ctl.wr_idx   = level_q;
		ctl.t        = t_q;
	end

	bez_lane u_lane_x (
		.clk         (clk),
		.ctl         (ctl),
		.load_coord  (item.coord_x),
		.final_coord (fin_x)
	);

	bez_lane u_lane_y (
		.clk         (clk),
		.ctl         (ctl),
		.load_coord  (item.coord_y),
		.final_coord (fin_y)
	);

	bez_lane u_lane_z (
		.clk         (clk),
		.ctl         (ctl),
		.load_coord  (item.coord_z),
		.final_coord (fin_z)
	);

	bez_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (merge_load),
		.lane_x       (fin_x),
		.lane_y       (fin_y),
		.lane_z       (fin_z),
		.free         (merge_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the de Casteljau Bezier curve evaluator.
module tb_top;
	import bez_pkg::*;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
	localparam int SETTLE_CYCLES = 80;

	class curve_scoreboard;
		logic signed [COORD_W-1:0] points [MAX_POINTS][3];
		logic [CNT_W-1:0] count_reg;
		result_t curve_q[$];
		int mismatches;
		int checked;
		int loads;
		int evals;
		int count_writes;

		function new();
			count_reg = POINTS_RST;
			foreach (points[i, c])
				points[i][c] = '0;
		endfunction

		function void set_count(logic [CNT_W-1:0] v);
			count_reg = v;
			count_writes++;
		endfunction

		function int pending();
			return curve_q.size();
		endfunction

		function logic signed [COORD_W-1:0] lerp(logic signed [COORD_W-1:0] a,
				logic signed [COORD_W-1:0] b, logic [T_W-1:0] t);
			longint d;
			longint p;
			longint r;
			d = longint'(b) - longint'(a);
			p = longint'(t) * d;
			r = longint'(a) + (p >>> T_FRAC_BITS);
			if (r > longint'(COORD_MAX))
				r = longint'(COORD_MAX);
			if (r < longint'(COORD_MIN))
				r = longint'(COORD_MIN);
			return r[COORD_W-1:0];
		endfunction

		function result_t eval_curve(logic [T_W-1:0] t_in);
			logic signed [COORD_W-1:0] work [MAX_POINTS][3];
			logic [T_W-1:0] t;
			result_t res;
			int n;
			n = int'(count_reg);
			if (n < int'(POINTS_MIN))
				n = int'(POINTS_MIN);
			if (n > MAX_POINTS)
				n = MAX_POINTS;
			t = (t_in > T_ONE) ? T_ONE : t_in;
			work = points;
			for (int level = n - 1; level >= 1; level--)
				for (int i = 0; i < level; i++)
					for (int c = 0; c < 3; c++)
						work[i][c] = lerp(work[i][c], work[i+1][c], t);
			res.curve_x = work[0][0];
			res.curve_y = work[0][1];
			res.curve_z = work[0][2];
			return res;
		endfunction

		function void note_item(item_t w);
			if (w.func == FUNC_LOAD) begin
				points[w.point_index][0] = w.coord_x;
				points[w.point_index][1] = w.coord_y;
				points[w.point_index][2] = w.coord_z;
				loads++;
			end else begin
				curve_q = {curve_q, eval_curve(w.t_value)};
				evals++;
			end
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (curve_q.size() == 0) begin
				report_mismatch($sformatf("curve point %h with none pending", got));
				return;
			end
			want = curve_q.pop_front();
			checked++;
			if (got.curve_x !== want.curve_x)
				report_mismatch($sformatf("curve_x got %h want %h", got.curve_x, want.curve_x));
			if (got.curve_y !== want.curve_y)
				report_mismatch($sformatf("curve_y got %h want %h", got.curve_y, want.curve_y));
			if (got.curve_z !== want.curve_z)
				report_mismatch($sformatf("curve_z got %h want %h", got.curve_z, want.curve_z));
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CNT_W-1:0] cfg_wr_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;

	curve_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	bezier_de_casteljau_eval_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[bezier_de_casteljau_eval_top] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3: return $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [T_W-1:0] rand_t();
		case ($urandom_range(9))
			0: return '0;
			1: return T_ONE;
			2: return T_ONE - 1;
			3: return T_W'($urandom_range(int'(T_ONE) + 1, (1 << T_W) - 1));
			default: return T_W'($urandom_range(0, int'(T_ONE)));
		endcase
	endfunction

	function automatic item_t make_load(int idx, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
		item_t w;
		w.func = FUNC_LOAD;
		w.point_index = 3'(idx);
		w.coord_x = x;
		w.coord_y = y;
		w.coord_z = z;
		w.t_value = T_W'($urandom);
		return w;
	endfunction

	function automatic item_t make_eval(logic [T_W-1:0] t);
		item_t w;
		w.func = FUNC_EVAL;
		w.point_index = 3'($urandom);
		w.coord_x = $urandom;
		w.coord_y = $urandom;
		w.coord_z = $urandom;
		w.t_value = t;
		return w;
	endfunction

	task automatic send_word(input item_t w);
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.note_item(w);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_count(v);
	endtask

	task automatic send_random(int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 30)
				send_word(make_load($urandom_range(MAX_POINTS - 1), rand_coord(),
					rand_coord(), rand_coord()));
			else
				send_word(make_eval(rand_t()));
		end
	endtask

	initial begin
		logic [CNT_W-1:0] count_plan [10];
		count_plan = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd5, 4'd1, 4'd9, 4'd3, 4'd7, 4'd6};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < MAX_POINTS; i++)
			send_word(make_load(i, i[0] ? COORD_MIN : COORD_MAX,
				i[0] ? COORD_MAX : COORD_MIN, i[1] ? 32'sh0001_0000 : -32'sd1));
		send_word(make_eval('0));
		send_word(make_eval(T_ONE));
		send_word(make_eval({T_W{1'b1}}));
		send_word(make_eval(T_W'(32768)));
		drain();
		write_count(POINTS_MIN);
		send_word(make_eval(T_W'(1)));
		send_word(make_eval(T_ONE - 1));
		drain();
		write_count(POINTS_MAX);
		send_word(make_eval(T_ONE + 1));
		send_word(make_eval(T_W'(12345)));
		drain();
		write_count(4'd0);
		send_word(make_eval(T_W'(40000)));
		drain();
		write_count(4'd15);
		send_word(make_eval(T_W'(777)));
		drain();

		for (int seg = 0; seg < 10; seg++) begin
			if (seg < 3) begin
				send_idle_pct = 7;
				recv_idle_pct = 47;
			end else if (seg < 6) begin
				send_idle_pct = 47;
				recv_idle_pct = 7;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_count(count_plan[seg]);
			send_random(56);
			if (seg == 7) begin
				hold_request = 300;
				for (int k = 0; k < 8; k++) begin
					send_word(make_eval(rand_t()));
					send_word(make_load($urandom_range(MAX_POINTS - 1), rand_coord(),
						rand_coord(), rand_coord()));
				end
			end
			send_random(57);
			drain();
		end

		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d curve points never arrived", sb.pending()));
		$display("Covered %0d point loads and %0d curve evaluations across %0d point-count writes.",
			sb.loads, sb.evals, sb.count_writes);
		$display("Compared %0d curve points, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("[bezier_de_casteljau_eval_top] OK");
		else
			$display("[bezier_de_casteljau_eval_top] ERROR");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/bez_pkg.sv
hw/rtl/bez_lane.sv
hw/rtl/bez_merge.sv
hw/rtl/bezier_de_casteljau_eval_top.sv
dv/tb_top.sv
